FILE: hdl/cpbs_pkg.sv
// Shared types and default constants for the complex power unit.
`timescale 1ns / 1ps
package cpbs_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 24;
    localparam int DEF_EXP_WIDTH  = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMUL,
        S_CWB,
        S_DRE_GO,
        S_DRE_WAIT,
        S_DIM_GO,
        S_DIM_WAIT,
        S_LOOP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_NORM,
        OP_ACC,
        OP_SQR,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

FILE: hdl/cpbs_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module cpbs_mul #(
    parameter int DATA_WIDTH = cpbs_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic signed [DATA_WIDTH-1:0]   i_a,
    input  logic signed [DATA_WIDTH-1:0]   i_b,
    output logic signed [2*DATA_WIDTH-1:0] o_p
);
    import cpbs_pkg::*;

    logic signed [2*DATA_WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: hdl/cpbs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cpbs_div #(
    parameter int NUM_WIDTH = 114,
    parameter int DIV_WIDTH = 65
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpbs_pkg::t_div_ctl   i_ctl,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DIV_WIDTH-1:0] i_div,
    output cpbs_pkg::t_div_ctl   o_ctl,
    output logic [NUM_WIDTH-1:0] o_quo
);
    import cpbs_pkg::*;

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [NUM_WIDTH-1:0] r_num, n_num;
    logic [NUM_WIDTH-1:0] r_quo, n_quo;
    logic [DIV_WIDTH-1:0] r_div, n_div;
    logic [DIV_WIDTH-1:0] r_rem, n_rem;
    logic [DIV_WIDTH:0]   rem_sh;
    logic [DIV_WIDTH:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_quo   = r_quo;
        n_div   = r_div;
        n_rem   = r_rem;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_div  = i_div;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_num = {r_num[NUM_WIDTH-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_div}) begin
                n_rem = rem_sub[DIV_WIDTH-1:0];
                n_quo = {r_quo[NUM_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DIV_WIDTH-1:0];
                n_quo = {r_quo[NUM_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(NUM_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quo       = r_quo;

endmodule

FILE: hdl/complex_power_by_squaring_core.sv
// Complex power by repeated squaring: top level with sequencer and datapath.
// Each complex multiply runs on the shared multiplier; an exponent magnitude of m bits takes
// up to 2*(m-1)+1 multiplies, and a zero exponent takes none.
// A negative exponent adds a norm multiply and two divides on the bit-serial divider,
// whose dividend is NW = max(DW+2F+1, 2DW)+1 bits wide.
// Throughput: one transaction at a time; the shared multiplier sets the loop rate.
// Reset: synchronous active-low i_rst_n clears the sequencer and output valid.
`timescale 1ns / 1ps
module complex_power_by_squaring_core #(
    parameter int DATA_WIDTH = cpbs_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = cpbs_pkg::DEF_FRAC_BITS,
    parameter int EXP_WIDTH  = cpbs_pkg::DEF_EXP_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_z_re,
    input  logic signed [DATA_WIDTH-1:0] i_z_im,
    input  logic signed [EXP_WIDTH-1:0]  i_exponent,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_overflow,
    output logic                         o_divide_by_zero
);
    import cpbs_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = 2 * DW + 1;
    localparam int NW  = ((DW + 2 * FRAC_BITS + 1 > 2 * DW) ?
                          (DW + 2 * FRAC_BITS + 1) : (2 * DW)) + 1;
    localparam int DVW = 2 * DW + 1;
    localparam logic signed [DW-1:0] ONE_V = (FRAC_BITS >= DW - 1) ?
        {1'b0, {(DW-1){1'b1}}} : (DW'(1) << FRAC_BITS);
    localparam logic signed [AW:0] HALF_V = (AW+1)'(1) << (FRAC_BITS - 1);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [2:0] r_k, n_k;
    logic [EXP_WIDTH-1:0] r_n, n_n;
    logic signed [DW-1:0] r_w_re, n_w_re, r_w_im, n_w_im;
    logic signed [DW-1:0] r_s_re, n_s_re, r_s_im, n_s_im;
    logic signed [AW-1:0] r_acc_re, n_acc_re, r_acc_im, n_acc_im;
    logic [2*DW-1:0] r_d, n_d;
    logic r_ov, n_ov, r_dz, n_dz;
    logic r_out_valid, n_out_valid;
    logic signed [DW-1:0] r_res_re, n_res_re, r_res_im, n_res_im;
    logic r_out_ov, n_out_ov, r_out_dz, n_out_dz;

    logic signed [DW-1:0] ar, ai, br, bi, ma, mb;
    logic signed [2*DW-1:0] prod;
    logic signed [AW-1:0] prod_x;
    logic signed [AW:0] rs_re, rs_im;
    logic signed [DW-1:0] rd_re, rd_im;
    logic ro_re, ro_im;
    logic [EXP_WIDTH-1:0] e_mag;
    logic signed [DW-1:0] dsel;
    logic [DW-1:0] dabs;
    logic dneg;
    logic [NW-1:0] div_num, quo;
    logic [DVW-1:0] div_den;
    t_div_ctl div_in, div_out;
    logic signed [DW-1:0] qval;
    logic qov;
    logic accept, out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign e_mag      = i_exponent[EXP_WIDTH-1] ? EXP_WIDTH'(-i_exponent)
                                                : EXP_WIDTH'(i_exponent);

    always_comb begin
        case (r_op)
            OP_ACC: begin
                ar = r_s_re; ai = r_s_im; br = r_w_re; bi = r_w_im;
            end
            OP_FIN: begin
                ar = r_w_re; ai = r_w_im; br = r_s_re; bi = r_s_im;
            end
            default: begin
                ar = r_w_re; ai = r_w_im; br = r_w_re; bi = r_w_im;
            end
        endcase
        case (r_k)
            3'd0:    begin ma = ar; mb = br; end
            3'd1:    begin ma = ai; mb = bi; end
            3'd2:    begin ma = ar; mb = bi; end
            default: begin ma = ai; mb = br; end
        endcase
    end

    cpbs_mul #(.DATA_WIDTH(DW)) u_mul (
        .i_clk (i_clk),
        .i_a   (ma),
        .i_b   (mb),
        .o_p   (prod)
    );

    assign prod_x = AW'(prod);

    always_comb begin
        rs_re = ($signed({r_acc_re[AW-1], r_acc_re}) + HALF_V) >>> FRAC_BITS;
        rs_im = ($signed({r_acc_im[AW-1], r_acc_im}) + HALF_V) >>> FRAC_BITS;
        ro_re = !((&rs_re[AW:DW-1]) || !(|rs_re[AW:DW-1]));
        ro_im = !((&rs_im[AW:DW-1]) || !(|rs_im[AW:DW-1]));
        rd_re = ro_re ? (rs_re[AW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                      : rs_re[DW-1:0];
        rd_im = ro_im ? (rs_im[AW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                      : rs_im[DW-1:0];
    end

    always_comb begin
        dsel    = (r_state == S_DIM_GO || r_state == S_DIM_WAIT) ? r_w_im : r_w_re;
        dabs    = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
        dneg    = (r_state == S_DIM_GO || r_state == S_DIM_WAIT) ? !dsel[DW-1]
                                                                 : dsel[DW-1];
        div_num = (NW'(dabs) << (2 * FRAC_BITS + 1)) + NW'(r_d);
        div_den = {r_d, 1'b0};
        div_in.start = (r_state == S_DRE_GO) || (r_state == S_DIM_GO);
        div_in.done  = 1'b0;
    end

    cpbs_div #(.NUM_WIDTH(NW), .DIV_WIDTH(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in),
        .i_num   (div_num),
        .i_div   (div_den),
        .o_ctl   (div_out),
        .o_quo   (quo)
    );

    always_comb begin
        if (dneg) begin
            qov  = !((quo[NW-1:DW-1] == '0) ||
                     (quo[NW-1:DW-1] == (NW-DW+1)'(1) && quo[DW-2:0] == '0));
            qval = qov ? {1'b1, {(DW-1){1'b0}}} : DW'(-quo[DW-1:0]);
        end else begin
            qov  = (quo[NW-1:DW-1] != '0);
            qval = qov ? {1'b0, {(DW-1){1'b1}}} : quo[DW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (e_mag == '0) begin
                        n_state = S_OUT;
                    end else if (i_exponent[EXP_WIDTH-1]) begin
                        n_state = (i_z_re == '0 && i_z_im == '0) ? S_OUT : S_CMUL;
                    end else begin
                        n_state = S_LOOP;
                    end
                end
            end
            S_CMUL:     if (r_k == 3'd4) n_state = S_CWB;
            S_CWB: begin
                case (r_op)
                    OP_NORM: n_state = S_DRE_GO;
                    OP_FIN:  n_state = S_OUT;
                    default: n_state = S_LOOP;
                endcase
            end
            S_DRE_GO:   n_state = S_DRE_WAIT;
            S_DRE_WAIT: if (div_out.done) n_state = S_DIM_GO;
            S_DIM_GO:   n_state = S_DIM_WAIT;
            S_DIM_WAIT: if (div_out.done) n_state = S_LOOP;
            S_LOOP:     n_state = S_CMUL;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op = r_op; n_k = r_k; n_n = r_n;
        n_w_re = r_w_re; n_w_im = r_w_im; n_s_re = r_s_re; n_s_im = r_s_im;
        n_acc_re = r_acc_re; n_acc_im = r_acc_im; n_d = r_d;
        n_ov = r_ov; n_dz = r_dz;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res_re = r_res_re; n_res_im = r_res_im;
        n_out_ov = r_out_ov; n_out_dz = r_out_dz;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_w_re = i_z_re; n_w_im = i_z_im;
                    n_s_re = ONE_V; n_s_im = '0;
                    n_n = e_mag; n_ov = 1'b0; n_dz = 1'b0;
                    n_op = OP_NORM; n_k = '0;
                    n_acc_re = '0; n_acc_im = '0;
                    if (e_mag == '0) begin
                        n_w_re = ONE_V; n_w_im = '0;
                    end else if (i_exponent[EXP_WIDTH-1] && i_z_re == '0 &&
                                 i_z_im == '0) begin
                        n_w_re = '0; n_w_im = '0; n_dz = 1'b1;
                    end
                end
            end
            S_CMUL: begin
                n_k = r_k + 3'd1;
                case (r_k)
                    3'd1: n_acc_re = r_acc_re + prod_x;
                    3'd2: n_acc_re = (r_op == OP_NORM) ? r_acc_re + prod_x
                                                       : r_acc_re - prod_x;
                    3'd3: n_acc_im = r_acc_im + prod_x;
                    3'd4: n_acc_im = r_acc_im + prod_x;
                    default: ;
                endcase
            end
            S_CWB: begin
                case (r_op)
                    OP_NORM: n_d = r_acc_re[2*DW-1:0];
                    OP_ACC: begin
                        n_s_re = rd_re; n_s_im = rd_im;
                        n_n = r_n - EXP_WIDTH'(1);
                        n_ov = r_ov | ro_re | ro_im;
                    end
                    OP_SQR: begin
                        n_w_re = rd_re; n_w_im = rd_im;
                        n_n = r_n >> 1;
                        n_ov = r_ov | ro_re | ro_im;
                    end
                    default: begin
                        n_w_re = rd_re; n_w_im = rd_im;
                        n_ov = r_ov | ro_re | ro_im;
                    end
                endcase
            end
            S_DRE_WAIT: begin
                if (div_out.done) begin
                    n_s_re = qval; n_ov = r_ov | qov;
                end
            end
            S_DIM_WAIT: begin
                if (div_out.done) begin
                    n_w_re = r_s_re; n_w_im = qval; n_s_re = ONE_V;
                    n_ov = r_ov | qov;
                end
            end
            S_LOOP: begin
                n_k = '0; n_acc_re = '0; n_acc_im = '0;
                if (r_n <= EXP_WIDTH'(1)) n_op = OP_FIN;
                else if (r_n[0])          n_op = OP_ACC;
                else                      n_op = OP_SQR;
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_res_re = r_w_re; n_res_im = r_w_im;
                    n_out_ov = r_ov; n_out_dz = r_dz;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= OP_NORM;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_k         <= n_k;
        end
        r_n <= n_n;
        r_w_re <= n_w_re; r_w_im <= n_w_im;
        r_s_re <= n_s_re; r_s_im <= n_s_im;
        r_acc_re <= n_acc_re; r_acc_im <= n_acc_im;
        r_d <= n_d; r_ov <= n_ov; r_dz <= n_dz;
        r_res_re <= n_res_re; r_res_im <= n_res_im;
        r_out_ov <= n_out_ov; r_out_dz <= n_out_dz;
    end

    assign o_out_valid      = r_out_valid;
    assign o_res_re         = r_res_re;
    assign o_res_im         = r_res_im;
    assign o_overflow       = r_out_ov;
    assign o_divide_by_zero = r_out_dz;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> (o_res_re == '0 && o_res_im == '0))
        else $error("divide transaction returned nonzero result");
    a_dz_no_ov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> !o_overflow)
        else $error("divide transaction raised overflow");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_out.done |-> (r_state == S_DRE_WAIT || r_state == S_DIM_WAIT))
        else $error("divider finished outside a wait state");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer did not leave idle after a transaction");
`endif

endmodule
